>>> sv/lphm_pkg.sv
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types and codes of the linear-probe hash map: operation codes,
// result status codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
`default_nettype none

package lphm_pkg;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_GET   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_ZERO_KEY = 2'd2;

  localparam int unsigned LIMIT_W   = 11;
  localparam int unsigned ENTRIES_W = 11;
  localparam int unsigned PORT_W    = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd768;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_COMP,
    ST_CLEAR,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;   // latch the input item, start the hash
    logic hash_issue;  // read home slot, load probe index
    logic advance;     // step to next slot and read it
    logic probe_end;   // latch the hit outcome
    logic sweep_init;  // reset probe index for a clear sweep
    logic sweep;       // zero key slot at probe index, step
    logic finish;      // commit the operation, load the result register
  } lphm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_e mode;
    logic  key_zero;
    logic  hash_ready;
    logic  key_hit;
    logic  key_empty;
    logic  sweep_last;
    logic  out_free;
  } lphm_sts_t;

endpackage

`default_nettype wire

>>> sv/linear_probe_hash_map_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_map_core
// Open-addressing hash map with linear probing: put, get and clear items.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        sink       in_valid_i / in_ready_o   mode_i, key_i, value_i
//  out       source     out_valid_o / out_ready_i found_o, read_value_o, status_o, entries_o
//  cfg       sink       cfg_valid_i / cfg_ready_o cfg_load_limit_i
//
//  Put/get: one key-store read per cycle while probing.
//  Zero key or unused mode skips the probe. Clear sweeps the key store, one slot a cycle.
//  Non-power-of-two CAPACITY reduces one key byte per cycle (at most 4) for the mod hash.
//  After reset the key store is swept empty, with in_ready_o low.
//  One item at a time; the result register frees the input side while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_map_core #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             found_o,
  output logic [31:0]      read_value_o,
  output logic [1:0]       status_o,
  output logic [10:0]      entries_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [10:0] cfg_load_limit_i
);

  lphm_pkg::lphm_cmd_t cmd;
  lphm_pkg::lphm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lphm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lphm_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_i),
    .key_i            (key_i),
    .value_i          (value_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_load_limit_i (cfg_load_limit_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .found_o          (found_o),
    .read_value_o     (read_value_o),
    .status_o         (status_o),
    .entries_o        (entries_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

  // ---------------- assertions ----------------
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_item, cmd.hash_issue, cmd.advance, cmd.sweep, cmd.finish}))
    else $error("more than one datapath command at once");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> sts.out_free)
    else $error("result loaded while previous result still held");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == lphm_pkg::STATUS_OK || status_o == lphm_pkg::STATUS_FULL ||
                     status_o == lphm_pkg::STATUS_ZERO_KEY))
    else $error("undefined status code");

endmodule

`default_nettype wire

>>> sv/lphm_ram.sv
// ----------------------------------------------------------------------------
// lphm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lphm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/lphm_ctrl.sv
// ----------------------------------------------------------------------------
// lphm_ctrl
// Operation sequencer: accept, hash, probe loop, clear sweep and result.
// ----------------------------------------------------------------------------
`default_nettype none

module lphm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lphm_pkg::lphm_sts_t sts_i,
  output lphm_pkg::lphm_cmd_t     cmd_o
);

  lphm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lphm_pkg::ST_INIT;  // key store is swept empty after reset
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      lphm_pkg::ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = lphm_pkg::ST_IDLE;
        end
      end
      lphm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = lphm_pkg::ST_HASH;
        end
      end
      lphm_pkg::ST_HASH: begin
        if (sts_i.mode == lphm_pkg::MODE_CLEAR) begin
          cmd_o.sweep_init = 1'b1;
          state_d          = lphm_pkg::ST_CLEAR;
        end else if (sts_i.mode == lphm_pkg::MODE_NOP || sts_i.key_zero) begin
          state_d = lphm_pkg::ST_DONE;
        end else if (sts_i.hash_ready) begin
          cmd_o.hash_issue = 1'b1;
          state_d          = lphm_pkg::ST_COMP;
        end
      end
      lphm_pkg::ST_COMP: begin
        if (sts_i.key_hit || sts_i.key_empty) begin
          cmd_o.probe_end = 1'b1;
          state_d         = lphm_pkg::ST_DONE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      lphm_pkg::ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = lphm_pkg::ST_DONE;
        end
      end
      lphm_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = lphm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lphm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/lphm_dp.sv
// ----------------------------------------------------------------------------
// lphm_dp
// Datapath: item registers, home-slot hash, probe index, key and value
// stores, entry count, load limit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lphm_dp #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [1:0]                      mode_i,
  input  wire logic [lphm_pkg::PORT_W-1:0]     key_i,
  input  wire logic [lphm_pkg::PORT_W-1:0]     value_i,
  input  wire logic                            cfg_valid_i,
  input  wire logic [lphm_pkg::LIMIT_W-1:0]    cfg_load_limit_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 found_o,
  output logic [lphm_pkg::PORT_W-1:0]          read_value_o,
  output logic [1:0]                           status_o,
  output logic [lphm_pkg::ENTRIES_W-1:0]       entries_o,
  input  wire lphm_pkg::lphm_cmd_t             cmd_i,
  output lphm_pkg::lphm_sts_t                  sts_o
);

  localparam int unsigned KW  = (KEY_BITS < lphm_pkg::PORT_W) ? KEY_BITS : lphm_pkg::PORT_W;
  localparam int unsigned VW  = (VALUE_BITS < lphm_pkg::PORT_W) ? VALUE_BITS : lphm_pkg::PORT_W;
  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned LW  = ((CW > lphm_pkg::LIMIT_W) ? CW : lphm_pkg::LIMIT_W) + 1;
  localparam int unsigned EW  = (LW > lphm_pkg::ENTRIES_W) ? LW : lphm_pkg::ENTRIES_W;
  localparam bit          POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

  lphm_pkg::mode_e          mode_q;
  logic [KW-1:0]            key_q;
  logic [VW-1:0]            val_q;
  logic [IW-1:0]            idx_q, idx_next, rd_idx, hash_idx;
  logic [CW-1:0]            count_q, count_d;
  logic [lphm_pkg::LIMIT_W-1:0] limit_q;
  logic                     hit_q;
  logic                     hash_ready;
  logic [KW-1:0]            key_rdata;
  logic [VW-1:0]            val_rdata;
  logic                     key_we, val_we;
  logic [KW-1:0]            key_wdata;

  logic                     out_valid_q, found_q;
  logic [lphm_pkg::PORT_W-1:0] rval_q;
  logic [1:0]               status_q;
  logic [lphm_pkg::ENTRIES_W-1:0] entries_q;

  logic                     is_put, is_get, key_zero, probe_op, full, insert_ok;
  logic [LW-1:0]            count_inc;
  logic [EW-1:0]            count_ext;

  // ---------------- item registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q <= lphm_pkg::mode_e'(mode_i);
      key_q  <= key_i[KW-1:0];
      val_q  <= value_i[VW-1:0];
    end
    if (cmd_i.probe_end) begin
      hit_q <= (key_rdata == key_q);
    end
  end

  // ---------------- home slot ----------------
  if (POW2) begin : g_hash_mask
    localparam int unsigned HW = (KW > IW) ? KW : IW;
    logic [HW-1:0] key_ext;
    assign key_ext    = HW'(key_q);
    assign hash_idx   = key_ext[IW-1:0];
    assign hash_ready = 1'b1;
  end else begin : g_hash_bytes
    // key mod CAPACITY, one key byte a cycle, top byte first; each step reduces
    // rem * 256 + byte with a reciprocal multiply that is exact over TW bits
    localparam int unsigned NB = (KW + 7) / 8;
    localparam int unsigned SW = 8 * NB;
    localparam int unsigned TW = IW + 8;
    localparam int unsigned MW = TW + 1;
    localparam int unsigned RS = TW + IW;
    localparam int unsigned NW = $clog2(NB + 1);
    localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RS) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
    localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];
    logic [IW-1:0]    rem_q;
    logic [SW-1:0]    shift_q;
    logic [NW-1:0]    bytes_q;
    logic [TW-1:0]    step;
    logic [TW+MW-1:0] prod;
    logic [TW-1:0]    quot;
    logic [TW-1:0]    rem_next;
    assign step     = {rem_q, shift_q[SW-1 -: 8]};
    assign prod     = (TW+MW)'(step) * (TW+MW)'(RECIP);
    assign quot     = TW'(prod[TW+MW-1:RS]);
    assign rem_next = step - TW'(quot * TW'(CAPACITY));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bytes_q <= '0;
      end else if (cmd_i.load_item) begin
        bytes_q <= NW'(NB);
      end else if (bytes_q != '0) begin
        bytes_q <= bytes_q - NW'(1);
      end
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.load_item) begin
        rem_q   <= '0;
        shift_q <= SW'(key_i[KW-1:0]);
      end else if (bytes_q != '0) begin
        rem_q   <= rem_next[IW-1:0];
        shift_q <= shift_q << 8;
      end
    end
    assign hash_idx   = rem_q;
    assign hash_ready = (bytes_q == '0);
  end

  // ---------------- probe index ----------------
  assign idx_next = (idx_q == IW'(CAPACITY - 1)) ? '0 : idx_q + IW'(1);

  always_comb begin
    rd_idx = idx_q;
    if (cmd_i.hash_issue) begin
      rd_idx = hash_idx;
    end else if (cmd_i.advance) begin
      rd_idx = idx_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.sweep_init) begin
      idx_q <= '0;
    end else if (cmd_i.hash_issue || cmd_i.advance || cmd_i.sweep) begin
      idx_q <= (cmd_i.sweep) ? idx_next : rd_idx;
    end
  end

  // ---------------- outcome ----------------
  assign is_put    = (mode_q == lphm_pkg::MODE_PUT);
  assign is_get    = (mode_q == lphm_pkg::MODE_GET);
  assign key_zero  = (key_q == '0);
  assign probe_op  = (is_put || is_get) && !key_zero;
  assign count_inc = LW'(count_q) + LW'(1);
  assign full      = (count_inc >= LW'(limit_q)) || (count_inc >= LW'(CAPACITY));
  assign insert_ok = probe_op && is_put && !hit_q && !full;

  always_comb begin
    count_d = count_q;
    if (cmd_i.sweep && (idx_q == IW'(CAPACITY - 1))) begin
      count_d = '0;
    end else if (cmd_i.finish && insert_ok) begin
      count_d = count_q + CW'(1);
    end
  end
  assign count_ext = EW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      limit_q <= lphm_pkg::LIMIT_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_load_limit_i;
      end
    end
  end

  // ---------------- stores ----------------
  assign key_we    = cmd_i.sweep || (cmd_i.finish && insert_ok);
  assign key_wdata = cmd_i.sweep ? '0 : key_q;
  assign val_we    = cmd_i.finish && probe_op && is_put && (hit_q || !full);

  lphm_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (idx_q),
    .wdata_i (key_wdata),
    .raddr_i (rd_idx),
    .rdata_o (key_rdata)
  );

  lphm_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (idx_q),
    .wdata_i (val_q),
    .raddr_i (idx_q),
    .rdata_o (val_rdata)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_q   <= probe_op && hit_q;
      rval_q    <= (probe_op && is_get && hit_q) ? lphm_pkg::PORT_W'(val_rdata) : '0;
      entries_q <= count_ext[lphm_pkg::ENTRIES_W-1:0];
      if ((is_put || is_get) && key_zero) begin
        status_q <= lphm_pkg::STATUS_ZERO_KEY;
      end else if (probe_op && is_put && !hit_q && full) begin
        status_q <= lphm_pkg::STATUS_FULL;
      end else begin
        status_q <= lphm_pkg::STATUS_OK;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign read_value_o = rval_q;
  assign status_o     = status_q;
  assign entries_o    = entries_q;

  assign sts_o.mode       = mode_q;
  assign sts_o.key_zero   = key_zero;
  assign sts_o.hash_ready = hash_ready;
  assign sts_o.key_hit    = (key_rdata == key_q);
  assign sts_o.key_empty  = (key_rdata == '0);
  assign sts_o.sweep_last = (idx_q == IW'(CAPACITY - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

>>> dv/linear_probe_hash_map_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map_core_tb
// Self-checking bench for the linear-probe hash map. A scoreboard keeps its
// own copy of the key and value slots and predicts every result; directed
// put/get/clear items come first, then random items over several load
// limits, a full-table fill and long probe chains around the last slot.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_core_tb;

  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned MAX_CYCLES  = 8_000_000;
  localparam int unsigned DRAIN_WAIT  = 2 * SLOTS + 16;

  typedef struct packed {
    logic                           found;
    logic [lphm_pkg::PORT_W-1:0]    read_value;
    logic [1:0]                     status;
    logic [lphm_pkg::ENTRIES_W-1:0] entries;
  } map_result_t;

  class hash_map_scoreboard;
    logic [31:0]                  key_slots[SLOTS];
    logic [31:0]                  value_slots[SLOTS];
    int unsigned                  count;
    logic [lphm_pkg::LIMIT_W-1:0] limit;
    map_result_t                  pending[$];
    int unsigned                  errors;

    function new();
      foreach (key_slots[i]) begin
        key_slots[i]   = '0;
        value_slots[i] = '0;
      end
      count  = 0;
      limit  = lphm_pkg::LIMIT_RESET;
      errors = 0;
    endfunction

    function void set_limit(logic [lphm_pkg::LIMIT_W-1:0] lim);
      limit = lim;
    endfunction

    function bit idle();
      return pending.size() == 0;
    endfunction

    // predict the result of one accepted item and update the table copy
    function void note_item(lphm_pkg::mode_e op, logic [31:0] key, logic [31:0] value);
      map_result_t res;
      int unsigned idx;
      int unsigned n;
      bit          hit;
      bit          empty_found;
      res         = '0;
      hit         = 1'b0;
      empty_found = 1'b0;
      idx         = 0;
      case (op)
        lphm_pkg::MODE_CLEAR: begin
          foreach (key_slots[i]) key_slots[i] = '0;
          count = 0;
        end
        lphm_pkg::MODE_PUT, lphm_pkg::MODE_GET: begin
          if (key == '0) begin
            res.status = lphm_pkg::STATUS_ZERO_KEY;
          end else begin
            idx = key % SLOTS;
            for (n = 0; n < SLOTS && !hit && !empty_found; n++) begin
              if (key_slots[idx] == '0) empty_found = 1'b1;
              else if (key_slots[idx] == key) hit = 1'b1;
              else idx = (idx + 1) % SLOTS;
            end
            if (op == lphm_pkg::MODE_GET) begin
              if (hit) begin
                res.found      = 1'b1;
                res.read_value = value_slots[idx];
              end
            end else if (hit) begin
              res.found        = 1'b1;
              value_slots[idx] = value;
            end else if (count + 1 >= limit || count + 1 >= SLOTS || !empty_found) begin
              res.status = lphm_pkg::STATUS_FULL;
            end else begin
              key_slots[idx]   = key;
              value_slots[idx] = value;
              count++;
            end
          end
        end
        default: ;
      endcase
      res.entries = lphm_pkg::ENTRIES_W'(count);
      pending.push_back(res);
    endfunction

    function void check_result(map_result_t got);
      map_result_t exp;
      if (pending.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.found !== exp.found) begin
        $error("found: expected %0d, got %0d", exp.found, got.found);
        errors++;
      end
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected 0x%08h, got 0x%08h", exp.read_value, got.read_value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.entries !== exp.entries) begin
        $error("entries: expected %0d, got %0d", exp.entries, got.entries);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   mode;
  logic [31:0]                  key;
  logic [31:0]                  value;
  logic                         out_valid;
  logic                         out_ready;
  logic                         found;
  logic [31:0]                  read_value;
  logic [1:0]                   status;
  logic [10:0]                  entries;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [lphm_pkg::LIMIT_W-1:0] cfg_limit;

  hash_map_scoreboard sb;
  logic [31:0]        key_pool[32];
  int unsigned        burst_left;
  int unsigned        stall_left;
  logic               ready_level;
  int unsigned        cycles;

  linear_probe_hash_map_core #(
    .CAPACITY   (SLOTS),
    .KEY_BITS   (32),
    .VALUE_BITS (32)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .mode_i           (mode),
    .key_i            (key),
    .value_i          (value),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .found_o          (found),
    .read_value_o     (read_value),
    .status_o         (status),
    .entries_o        (entries),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_load_limit_i (cfg_limit)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: stall pattern of long ready stretches, short stalls and noise
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          ready_level = 1'b1;
          stall_left  = $urandom_range(40, 200);
        end
        1: begin
          ready_level = 1'b0;
          stall_left  = $urandom_range(1, 8);
        end
        default: begin
          ready_level = 1'($urandom_range(0, 1));
          stall_left  = $urandom_range(1, 4);
        end
      endcase
    end
    stall_left--;
    out_ready <= ready_level;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{found, read_value, status, entries});
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // bursts of items with random gaps; called at a falling edge
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(lphm_pkg::mode_e op, logic [31:0] k, logic [31:0] v);
    pace();
    in_valid <= 1'b1;
    mode     <= op;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, k, v);
    @(negedge clk);
  endtask

  // lower valid and wait for every pending result before a config change
  task automatic drain_items();
    in_valid <= 1'b0;
    burst_left = 0;
    while (!sb.idle()) @(negedge clk);
  endtask

  task automatic write_limit(logic [lphm_pkg::LIMIT_W-1:0] lim);
    drain_items();
    cfg_valid <= 1'b1;
    cfg_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(lim);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return key_pool[$urandom_range(0, 31)];
    end else if (r < 75) begin
      // home slots around the wrap point build long chains
      k = ($urandom() & 32'hFFFF_FC00) | ((32'd1020 + $urandom_range(0, 7)) & 32'h3FF);
    end else if (r < 80) begin
      return '0;
    end else begin
      k = $urandom();
    end
    key_pool[$urandom_range(0, 31)] = k;
    return k;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_random(int unsigned n, bit allow_clear);
    int unsigned     r;
    lphm_pkg::mode_e op;
    repeat (n) begin
      r = $urandom_range(0, 199);
      if (r < 100) op = lphm_pkg::MODE_PUT;
      else if (r < 186) op = lphm_pkg::MODE_GET;
      else if (r < 194 || !allow_clear) op = lphm_pkg::MODE_NOP;
      else op = lphm_pkg::MODE_CLEAR;
      send_item(op, pick_key(), pick_value());
    end
  endtask

  // one key per home slot, so the table fills with single-slot probes
  task automatic fill_table();
    logic [31:0] k;
    for (int unsigned s = 0; s < SLOTS; s++) begin
      k = {1'b1, 21'($urandom()), 10'(s)};
      if ($urandom_range(0, 7) == 0) key_pool[$urandom_range(0, 31)] = k;
      send_item(lphm_pkg::MODE_PUT, k, $urandom());
    end
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    mode        = lphm_pkg::MODE_NOP;
    key         = '0;
    value       = '0;
    out_ready   = 1'b1;
    cfg_valid   = 1'b0;
    cfg_limit   = lphm_pkg::LIMIT_RESET;
    burst_left  = 0;
    stall_left  = 0;
    ready_level = 1'b1;
    cycles      = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero keys, extremes, wrap-around chain at the last slot
    send_item(lphm_pkg::MODE_PUT,   32'h0000_0000, 32'hFFFF_FFFF);
    send_item(lphm_pkg::MODE_GET,   32'h0000_0000, 32'h0000_0000);
    send_item(lphm_pkg::MODE_PUT,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(lphm_pkg::MODE_PUT,   32'h0000_03FF, 32'h0000_0000);
    send_item(lphm_pkg::MODE_PUT,   32'h0000_07FF, 32'hA5A5_A5A5);
    send_item(lphm_pkg::MODE_PUT,   32'h0000_0001, 32'h5A5A_5A5A);
    send_item(lphm_pkg::MODE_GET,   32'h0000_03FF, 32'hFFFF_FFFF);
    send_item(lphm_pkg::MODE_GET,   32'h0000_0001, 32'h0000_0000);
    send_item(lphm_pkg::MODE_GET,   32'h0000_0BFF, 32'h0000_0000);
    send_item(lphm_pkg::MODE_PUT,   32'hFFFF_FFFF, 32'h1234_5678);
    send_item(lphm_pkg::MODE_GET,   32'hFFFF_FFFF, 32'h0000_0000);
    send_item(lphm_pkg::MODE_NOP,   32'h0000_0005, 32'hFFFF_FFFF);
    send_item(lphm_pkg::MODE_NOP,   32'h0000_0000, 32'h0000_0000);
    send_item(lphm_pkg::MODE_PUT,   32'h8000_0000, 32'h0000_0001);
    send_item(lphm_pkg::MODE_GET,   32'h8000_0000, 32'h0000_0000);
    send_item(lphm_pkg::MODE_CLEAR, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
    send_item(lphm_pkg::MODE_GET,   32'hFFFF_FFFF, 32'h0000_0000);
    send_item(lphm_pkg::MODE_PUT,   32'h0000_0400, 32'hFFFF_FFFF);
    send_item(lphm_pkg::MODE_GET,   32'h0000_0400, 32'h0000_0000);
    run_random(100, 1'b1);

    // limit of 2: one entry fits, further new keys are refused
    write_limit(11'd2);
    send_item(lphm_pkg::MODE_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_item(lphm_pkg::MODE_PUT,   32'h0000_0123, 32'h0000_0011);
    send_item(lphm_pkg::MODE_PUT,   32'h0000_0124, 32'h0000_0022);
    send_item(lphm_pkg::MODE_PUT,   32'h0000_0123, 32'h0000_0033);
    send_item(lphm_pkg::MODE_GET,   32'h0000_0124, 32'h0000_0000);
    run_random(50, 1'b1);

    write_limit(11'd0);
    run_random(30, 1'b1);

    write_limit(11'd40);
    run_random(100, 1'b1);

    // fill to the capacity bound, then search a nearly full table
    write_limit(11'd1024);
    send_item(lphm_pkg::MODE_CLEAR, 32'h0000_0000, 32'h0000_0000);
    fill_table();
    run_random(80, 1'b0);

    write_limit(11'h7FF);
    run_random(50, 1'b0);
    send_item(lphm_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 32'h0000_0000);

    write_limit(lphm_pkg::LIMIT_RESET);
    run_random(50, 1'b1);

    drain_items();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.idle()) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lphm_pkg.sv
sv/lphm_ram.sv
sv/lphm_ctrl.sv
sv/lphm_dp.sv
sv/linear_probe_hash_map_core.sv
dv/linear_probe_hash_map_core_tb.sv
